### hdl/shlc_pkg.sv
// Package for the string hash block: hash constants, unit-type codes and the
// command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package shlc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] MIX_C1    = 32'h85EB_CA6B;
  localparam logic [31:0] MIX_C2    = 32'hC2B2_AE35;

  localparam logic [7:0]  CONT_MASK = 8'hC0;
  localparam logic [7:0]  CONT_CODE = 8'h80;
  localparam logic [15:0] HI_SUR_LO = 16'hD800;
  localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
  localparam logic [15:0] LO_SUR_LO = 16'hDC00;
  localparam logic [15:0] LO_SUR_HI = 16'hDFFF;

  typedef enum logic [1:0] {
    UNIT_UTF8  = 2'd0,
    UNIT_UTF16 = 2'd1,
    UNIT_UTF32 = 2'd2,
    UNIT_RSVD  = 2'd3
  } unit_type_t;

  // Register index of the unit type register.
  localparam logic REG_UNIT_TYPE = 1'b0;

  typedef struct packed {
    logic step;  // fold a non-zero unit into the running state
    logic term;  // terminator: first finalizer round, clear string state
    logic mix;   // second finalizer round
    logic emit;  // load the output registers
  } cmd_t;

  typedef struct packed {
    logic unit_zero;
  } sts_t;

endpackage

`default_nettype wire

### hdl/shlc_datapath.sv
// Datapath of the string hash block: running hash, byte and character counts,
// surrogate tracking, the two finalizer rounds and the output registers.
// Depends on shlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shlc_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire shlc_pkg::unit_type_t mode,
  input  wire logic [31:0]          code_unit,
  input  wire shlc_pkg::cmd_t       cmd,
  output shlc_pkg::sts_t            sts,
  output logic [31:0]               hash_value,
  output logic [31:0]               byte_length,
  output logic [31:0]               char_length
);

  logic [31:0] hash_r, hash_nxt;
  logic [31:0] byte_r, byte_nxt;
  logic [31:0] char_r, char_nxt;
  logic        hs_r, hs_nxt;
  logic [31:0] fin_r, fin_nxt;
  logic [31:0] blen_r, blen_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;
  logic [31:0] out_blen_r, out_blen_nxt;
  logic [31:0] out_clen_r, out_clen_nxt;

  logic [31:0] unit;
  logic [31:0] unit_bytes;
  logic        is_hi, is_lo, pair, is_char;
  logic [31:0] fold1, fold2;

  always_comb begin
    case (mode)
      shlc_pkg::UNIT_UTF8: begin
        unit       = {24'd0, code_unit[7:0]};
        unit_bytes = 32'd1;
      end
      shlc_pkg::UNIT_UTF16: begin
        unit       = {16'd0, code_unit[15:0]};
        unit_bytes = 32'd2;
      end
      default: begin
        unit       = code_unit;
        unit_bytes = 32'd4;
      end
    endcase
  end

  assign sts.unit_zero = (unit == 32'd0);

  // Surrogate ranges only matter in UTF-16 mode, where unit fits in 16 bits.
  assign is_hi = (mode == shlc_pkg::UNIT_UTF16) &&
                 (unit[15:0] >= shlc_pkg::HI_SUR_LO) && (unit[15:0] <= shlc_pkg::HI_SUR_HI);
  assign is_lo = (mode == shlc_pkg::UNIT_UTF16) &&
                 (unit[15:0] >= shlc_pkg::LO_SUR_LO) && (unit[15:0] <= shlc_pkg::LO_SUR_HI);
  assign pair  = hs_r && is_lo;
  assign is_char = (mode != shlc_pkg::UNIT_UTF8) ||
                   ((unit[7:0] & shlc_pkg::CONT_MASK) != shlc_pkg::CONT_CODE);

  assign fold1 = hash_r ^ {16'd0, hash_r[31:16]};
  assign fold2 = fin_r ^ {13'd0, fin_r[31:13]};

  always_comb begin
    hash_nxt     = hash_r;
    byte_nxt     = byte_r;
    char_nxt     = char_r;
    hs_nxt       = hs_r;
    fin_nxt      = fin_r;
    blen_nxt     = blen_r;
    clen_nxt     = clen_r;
    out_hash_nxt = out_hash_r;
    out_blen_nxt = out_blen_r;
    out_clen_nxt = out_clen_r;
    if (cmd.step) begin
      hs_nxt = is_hi && !pair;
      if (pair) begin
        byte_nxt = byte_r + 32'd2;
      end else begin
        hash_nxt = hash_r * shlc_pkg::FNV_PRIME + unit;
        byte_nxt = byte_r + unit_bytes;
        char_nxt = char_r + {31'd0, is_char};
      end
    end
    if (cmd.term) begin
      fin_nxt  = fold1 * shlc_pkg::MIX_C1;
      blen_nxt = byte_r + unit_bytes;
      clen_nxt = char_r;
      hash_nxt = shlc_pkg::FNV_BASIS;
      byte_nxt = 32'd0;
      char_nxt = 32'd0;
      hs_nxt   = 1'b0;
    end
    if (cmd.mix) begin
      fin_nxt = fold2 * shlc_pkg::MIX_C2;
    end
    if (cmd.emit) begin
      out_hash_nxt = fin_r ^ {16'd0, fin_r[31:16]};
      out_blen_nxt = blen_r;
      out_clen_nxt = clen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= shlc_pkg::FNV_BASIS;
      byte_r <= 32'd0;
      char_r <= 32'd0;
      hs_r   <= 1'b0;
    end else begin
      hash_r <= hash_nxt;
      byte_r <= byte_nxt;
      char_r <= char_nxt;
      hs_r   <= hs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r      <= fin_nxt;
    blen_r     <= blen_nxt;
    clen_r     <= clen_nxt;
    out_hash_r <= out_hash_nxt;
    out_blen_r <= out_blen_nxt;
    out_clen_r <= out_clen_nxt;
  end

  assign hash_value  = out_hash_r;
  assign byte_length = out_blen_r;
  assign char_length = out_clen_r;

  // The string state is back at its reset values after a terminator.
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.term |=> (hash_r == shlc_pkg::FNV_BASIS) && (byte_r == 32'd0) &&
                 (char_r == 32'd0) && !hs_r)
    else $error("string state not cleared after terminator");

  // A surrogate mark can only be left behind by a UTF-16 unit.
  a_mark_utf16: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(hs_r) |-> $past(cmd.step && (mode == shlc_pkg::UNIT_UTF16)))
    else $error("surrogate mark set outside UTF-16 step");

endmodule

`default_nettype wire

### hdl/shlc_ctrl.sv
// Controller of the string hash block: sequences the finalizer rounds after a
// terminator and owns the input ready and output valid handshakes.
// Depends on shlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shlc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire shlc_pkg::sts_t sts,
  output shlc_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_take;
  logic   out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign cmd.step = in_take && !sts.unit_zero;
  assign cmd.term = in_take && sts.unit_zero;
  assign cmd.mix  = (state_r == S_MIX);
  assign cmd.emit = (state_r == S_EMIT) && out_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd.term) begin
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Hold the finished hash until the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_term_to_mix: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.term |=> (state_r == S_MIX))
    else $error("terminator did not start the finalizer");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted item not presented");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("output valid raised outside emit");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !(cmd.step || cmd.term))
    else $error("item taken while finalizing");

endmodule

`default_nettype wire

### hdl/string_hash_with_length_count.sv
// String hash with length count. Takes a nul-terminated string one code unit
// per item (UTF-8, UTF-16 or UTF-32, set by the unit type register at byte
// address 0) and folds each non-zero unit, but the low half of a surrogate
// pair, into a 32-bit FNV-1 style hash while counting bytes and characters.
// A non-zero unit is taken whenever the block is idle; the multiply by the FNV
// prime is combinational. A zero unit ends the string: its item does the first
// constant multiply of the MurmurHash3 finalizer, the mix state the second, and
// the emit state loads the result, waiting there while the previous result has
// not yet been taken. The input is not ready again until the result is loaded.
// Units after the terminator are taken while the result waits at the output.
// Depends on shlc_pkg, shlc_ctrl and shlc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module string_hash_with_length_count (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [31:0]                   in_code_unit,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [31:0]                        out_hash_value,
  output logic [31:0]                        out_byte_length,
  output logic [31:0]                        out_char_length,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [shlc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [shlc_pkg::DATA_W-1:0]   pwdata,
  output logic [shlc_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);

  shlc_pkg::unit_type_t unit_type_r, unit_type_nxt;
  shlc_pkg::cmd_t       cmd;
  shlc_pkg::sts_t       sts;
  logic                 reg_sel;
  logic                 reg_wr;

  // Register index is the word address; only the unit type register exists.
  assign reg_sel = (paddr[shlc_pkg::ADDR_W-1] == shlc_pkg::REG_UNIT_TYPE);
  assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign pready  = 1'b1;

  always_comb begin
    unit_type_nxt = unit_type_r;
    if (reg_wr) begin
      unit_type_nxt = shlc_pkg::unit_type_t'(pwdata[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_type_r <= shlc_pkg::UNIT_UTF8;
    end else begin
      unit_type_r <= unit_type_nxt;
    end
  end

  assign prdata = reg_sel ? {{(shlc_pkg::DATA_W-2){1'b0}}, unit_type_r}
                          : {shlc_pkg::DATA_W{1'b0}};

  shlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  shlc_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .mode        (unit_type_r),
    .code_unit   (in_code_unit),
    .cmd         (cmd),
    .sts         (sts),
    .hash_value  (out_hash_value),
    .byte_length (out_byte_length),
    .char_length (out_char_length)
  );

endmodule

`default_nettype wire

### dv/tb_string_hash_with_length_count.sv
// Self-checking testbench for string_hash_with_length_count: streams nul-terminated
// strings in every unit mode and checks each hash and length result against a predictor.
// Depends on shlc_pkg and the string_hash_with_length_count RTL.
`timescale 1ns / 1ps

module tb_string_hash_with_length_count;
  import shlc_pkg::*;

  localparam logic [ADDR_W-1:0] UNIT_TYPE_ADDR = ADDR_W'(4 * REG_UNIT_TYPE);
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned PHASE_UNITS = 135;

  typedef struct packed {
    logic [31:0] hash_value;
    logic [31:0] byte_length;
    logic [31:0] char_length;
  } str_digest_t;

  // Tracks the running string state and holds the digests still owed by the block.
  class digest_tracker;
    unit_type_t mode;
    logic [31:0] run_hash;
    logic [31:0] byte_cnt;
    logic [31:0] char_cnt;
    logic hi_seen;
    str_digest_t pending[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned units_seen;

    function new();
      mode = UNIT_UTF8;
      mismatches = 0;
      checked = 0;
      units_seen = 0;
      clear_string();
    endfunction

    function void clear_string();
      run_hash = FNV_BASIS;
      byte_cnt = '0;
      char_cnt = '0;
      hi_seen = 1'b0;
    endfunction

    function logic [31:0] murmur_mix(logic [31:0] h);
      h = h ^ (h >> 16);
      h = h * MIX_C1;
      h = h ^ (h >> 13);
      h = h * MIX_C2;
      h = h ^ (h >> 16);
      return h;
    endfunction

    function void take_unit(logic [31:0] raw);
      logic [31:0] u;
      logic [31:0] nbytes;
      logic had_hi;
      str_digest_t d;
      units_seen++;
      case (mode)
        UNIT_UTF8: begin
          u = {24'b0, raw[7:0]};
          nbytes = 1;
        end
        UNIT_UTF16: begin
          u = {16'b0, raw[15:0]};
          nbytes = 2;
        end
        default: begin
          u = raw;
          nbytes = 4;
        end
      endcase
      if (u == 0) begin
        d.hash_value = murmur_mix(run_hash);
        d.byte_length = byte_cnt + nbytes;
        d.char_length = char_cnt;
        pending.push_back(d);
        clear_string();
        return;
      end
      if (mode == UNIT_UTF16) begin
        had_hi = hi_seen;
        hi_seen = 1'b0;
        // The second half of a surrogate pair only adds its bytes.
        if (had_hi && u[15:0] >= LO_SUR_LO && u[15:0] <= LO_SUR_HI) begin
          byte_cnt = byte_cnt + 2;
          return;
        end
        if (u[15:0] >= HI_SUR_LO && u[15:0] <= HI_SUR_HI) hi_seen = 1'b1;
      end else begin
        hi_seen = 1'b0;
      end
      run_hash = run_hash * FNV_PRIME + u;
      byte_cnt = byte_cnt + nbytes;
      if (mode != UNIT_UTF8 || (u[7:0] & CONT_MASK) != CONT_CODE) char_cnt = char_cnt + 1;
    endfunction

    function void check_digest(str_digest_t got);
      str_digest_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no string pending: hash %h bytes %0d chars %0d",
                 $time, got.hash_value, got.byte_length, got.char_length);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.hash_value !== want.hash_value) begin
        $display("%0t: hash_value expected %h actual %h", $time, want.hash_value,
                 got.hash_value);
        mismatches++;
      end
      if (got.byte_length !== want.byte_length) begin
        $display("%0t: byte_length expected %0d actual %0d", $time, want.byte_length,
                 got.byte_length);
        mismatches++;
      end
      if (got.char_length !== want.char_length) begin
        $display("%0t: char_length expected %0d actual %0d", $time, want.char_length,
                 got.char_length);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [31:0] in_code_unit;
  logic out_valid;
  logic out_ready;
  logic [31:0] out_hash_value;
  logic [31:0] out_byte_length;
  logic [31:0] out_char_length;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  digest_tracker sb;
  logic [31:0] str_buf[$];
  int unsigned cfg_errors;
  int unsigned idle_cycles;
  int unsigned strings_sent;
  bit tx_quiet;
  bit rx_quiet;
  bit rx_hold_req;
  bit short_strings;

  string_hash_with_length_count dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_unit   (in_code_unit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .out_byte_length(out_byte_length),
    .out_char_length(out_char_length),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.take_unit(in_code_unit);
    if (rst_n && out_valid && out_ready)
      sb.check_digest('{out_hash_value, out_byte_length, out_char_length});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left = RX_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (rx_quiet || $urandom_range(99) < 70) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        stall_left = pick_gap(1'b0);
      end
    end
  end

  // Bits above the mode's width are sometimes set at random, since the block must ignore them.
  function automatic void push_unit(unit_type_t m, logic [31:0] u);
    if ($urandom_range(3) == 0) begin
      if (m == UNIT_UTF8) u = u | ($urandom() & 32'hFFFF_FF00);
      else if (m == UNIT_UTF16) u = u | ($urandom() & 32'hFFFF_0000);
    end
    str_buf.push_back(u);
  endfunction

  function automatic logic [31:0] cont_byte();
    return 32'h80 | $urandom_range(0, 63);
  endfunction

  function automatic void build_string(unit_type_t m, int unsigned nchars);
    logic [31:0] r;
    str_buf.delete();
    repeat (nchars) begin
      if (m == UNIT_UTF8) begin
        case ($urandom_range(5))
          0, 1: push_unit(m, $urandom_range(1, 8'h7F));
          2: begin
            push_unit(m, $urandom_range(8'hC2, 8'hDF));
            push_unit(m, cont_byte());
          end
          3: begin
            push_unit(m, $urandom_range(8'hE0, 8'hEF));
            push_unit(m, cont_byte());
            push_unit(m, cont_byte());
          end
          4: begin
            push_unit(m, $urandom_range(8'hF0, 8'hF4));
            repeat (3) push_unit(m, cont_byte());
          end
          default: push_unit(m, $urandom_range(1, 8'hFF));
        endcase
      end else if (m == UNIT_UTF16) begin
        case ($urandom_range(5))
          0: push_unit(m, $urandom_range(1, 16'hD7FF));
          1: push_unit(m, $urandom_range(16'hE000, 16'hFFFF));
          2: begin
            push_unit(m, $urandom_range(HI_SUR_LO, HI_SUR_HI));
            push_unit(m, $urandom_range(LO_SUR_LO, LO_SUR_HI));
          end
          3: begin
            push_unit(m, $urandom_range(HI_SUR_LO, HI_SUR_HI));
            push_unit(m, $urandom_range(1, 16'hD7FF));
          end
          4: push_unit(m, $urandom_range(LO_SUR_LO, LO_SUR_HI));
          default: begin
            push_unit(m, $urandom_range(HI_SUR_LO, HI_SUR_HI));
            push_unit(m, $urandom_range(HI_SUR_LO, HI_SUR_HI));
            push_unit(m, $urandom_range(LO_SUR_LO, LO_SUR_HI));
          end
        endcase
      end else begin
        case ($urandom_range(2))
          0: push_unit(m, $urandom_range(1, 8'hFF));
          1: push_unit(m, $urandom_range(1, 32'h10_FFFF));
          default: begin
            r = $urandom();
            push_unit(m, (r == 0) ? 32'h1 : r);
          end
        endcase
      end
    end
    // A terminator may carry set bits above the mode's width.
    if (m != UNIT_UTF8 && m != UNIT_UTF16) r = '0;
    else if ($urandom_range(3) != 0) r = '0;
    else r = $urandom() & ((m == UNIT_UTF8) ? 32'hFFFF_FF00 : 32'hFFFF_0000);
    str_buf.push_back(r);
  endfunction

  task automatic send_unit(input logic [31:0] u, input int unsigned gap);
    @(negedge clk);
    in_valid = 1'b1;
    in_code_unit = u;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_code_unit = $urandom();
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_string();
    foreach (str_buf[i]) send_unit(str_buf[i], pick_gap(tx_quiet));
    strings_sent++;
  endtask

  // Hold the input off until every result is in and the block has settled.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_unit_type(input unit_type_t m);
    logic [31:0] wdata;
    wdata = ($urandom() & ~32'h3) | 32'(m);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = UNIT_TYPE_ADDR;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.mode = unit_type_t'(wdata[1:0]);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[1:0] !== wdata[1:0]) begin
      $display("%0t: unit_type readback expected %0d actual %0d", $time, wdata[1:0],
               prdata[1:0]);
      cfg_errors++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic send_list(input logic [31:0] units[$]);
    foreach (units[i]) send_unit(units[i], pick_gap(tx_quiet));
  endtask

  initial begin
    unit_type_t mode_seq[11];
    int unsigned phase_units;
    mode_seq = '{UNIT_UTF8, UNIT_UTF16, UNIT_UTF32, UNIT_RSVD, UNIT_UTF16, UNIT_UTF8,
                 UNIT_UTF32, UNIT_UTF16, UNIT_UTF8, UNIT_RSVD, UNIT_UTF16};
    sb = new();
    cfg_errors = 0;
    idle_cycles = 0;
    strings_sent = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rx_hold_req = 1'b0;
    short_strings = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_code_unit = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // UTF-8: empty string, byte extremes, continuation bytes, masked terminator.
    write_unit_type(UNIT_UTF8);
    send_list('{32'h0, 32'h41, 32'hFF, 32'h80, 32'hC3, 32'hBF, 32'h100,
                32'hFFFF_FF7F, 32'h0});
    wait_idle();
    // UTF-16: pair, lone high, repeated high then low, stray low, masked terminator.
    write_unit_type(UNIT_UTF16);
    send_list('{32'hD800, 32'hDC00, 32'hD83D, 32'h0041, 32'hDBFF, 32'hDBFF, 32'hDFFF,
                32'hDC00, 32'hFFFF, 32'hFFFF_0000});
    wait_idle();
    write_unit_type(UNIT_UTF32);
    send_list('{32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 32'h0});
    wait_idle();
    // The reserved code behaves as UTF-32.
    write_unit_type(UNIT_RSVD);
    send_list('{32'h1234_5678, 32'h0});
    wait_idle();
    // Mode changes inside one string: the surrogate mark must not survive a UTF-8 unit.
    write_unit_type(UNIT_UTF16);
    send_list('{32'hD800});
    wait_idle();
    write_unit_type(UNIT_UTF8);
    send_list('{32'hDC});
    wait_idle();
    write_unit_type(UNIT_UTF16);
    send_list('{32'hDC00, 32'h0});
    wait_idle();

    foreach (mode_seq[p]) begin
      write_unit_type(mode_seq[p]);
      tx_quiet = (p == 2) ? 1'b1 : ($urandom_range(3) == 0);
      rx_quiet = (p == 2) ? 1'b1 : ($urandom_range(3) == 0);
      // One phase of short strings against a long result stall fills the block.
      short_strings = (p == 4);
      if (p == 4) begin
        tx_quiet = 1'b1;
        rx_hold_req = 1'b1;
      end
      phase_units = 0;
      while (phase_units < PHASE_UNITS) begin
        if (short_strings) build_string(mode_seq[p], $urandom_range(0, 1));
        else if ($urandom_range(9) == 0) build_string(mode_seq[p], $urandom_range(20, 60));
        else build_string(mode_seq[p], $urandom_range(0, 8));
        phase_units += str_buf.size();
        send_string();
      end
      wait_idle();
    end

    $display("Sent %0d units in %0d random strings over all unit modes; %0d results checked.",
             sb.units_seen, strings_sent, sb.checked);
    $display("Mismatches: %0d, register readback errors: %0d, results still owed: %0d.",
             sb.mismatches, cfg_errors, sb.pending.size());
    if (sb.mismatches == 0 && cfg_errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/shlc_pkg.sv
hdl/shlc_datapath.sv
hdl/shlc_ctrl.sv
hdl/string_hash_with_length_count.sv
dv/tb_string_hash_with_length_count.sv
